// ----- rtl/ebid_pkg.sv -----
// Package: shared constants, types and helpers of the build-id note scanner.
package ebid_pkg;

  // Default depth of the build-id store, in bytes
  localparam int unsigned MAX_ID_BYTES_DEF = 64;

  // Note fields that identify the build-id note
  localparam logic [31:0] NOTE_TYPE_BUILD_ID = 32'd3;
  localparam logic [31:0] NOTE_NAME_SIZE     = 32'd4;
  localparam logic [3:0]  HDR_LAST_IDX       = 4'd11;

  // Result status codes
  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NONE  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  // Datapath to controller
  typedef struct packed {
    logic start_run;  // accepted beat completes a storable descriptor
    logic out_free;   // output register can take a result this cycle
    logic rd_left;    // stored bytes remain to be read out
    logic rd_hold;    // store read data is waiting to be sent
  } ebid_sts_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input beat accepted
    logic issue;      // read next stored byte
    logic load_run;   // move store read data into output register
  } ebid_cmd_t;

  // Expected name bytes "GNU\0"
  function automatic logic [7:0] gnu_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h47;
      2'd1:    b = 8'h4E;
      2'd2:    b = 8'h55;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/ebid_in_if.sv -----
// Interface: input channel, one note-region byte per beat.
interface ebid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] note_byte;
  logic       last_byte;

  modport source (output valid, output note_byte, output last_byte, input ready);
  modport sink   (input valid, input note_byte, input last_byte, output ready);
endinterface

// ----- rtl/ebid_out_if.sv -----
// Interface: result channel, one status/id byte per beat.
interface ebid_out_if;
  logic                valid;
  logic                ready;
  ebid_pkg::status_t   status;
  logic [7:0]          id_byte;
  logic                last_of_run;

  modport source (output valid, output status, output id_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input status, input id_byte, input last_of_run,
                  output ready);
endinterface

// ----- rtl/ebid_ctrl.sv -----
// Controller: intake versus read-out of the stored build id.
module ebid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ebid_pkg::ebid_sts_t sts,
  output ebid_pkg::ebid_cmd_t cmd
);
  import ebid_pkg::*;

  typedef enum logic [1:0] {
    S_RUN   = 2'b01,
    S_DRAIN = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  // Handshake and read-out commands
  always_comb begin
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_run = 1'b0;
    unique case (state_r)
      S_RUN: begin
        in_ready = sts.out_free;
        cmd.take = in_valid & sts.out_free;
      end
      S_DRAIN: begin
        cmd.load_run = sts.rd_hold & sts.out_free;
        cmd.issue    = sts.rd_left & (~sts.rd_hold | cmd.load_run);
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RUN:   if (cmd.take && sts.start_run) state_nxt = S_DRAIN;
      S_DRAIN: if (cmd.load_run && !sts.rd_left) state_nxt = S_RUN;
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A completed storable descriptor always starts a read-out
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && sts.start_run |=> state_r == S_DRAIN)
    else $error("read-out did not start");

  // No intake during read-out
  a_no_take_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> !cmd.take && !in_ready)
    else $error("beat taken during read-out");

  // Loads only into a free output register, with data present
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_run |-> sts.out_free && sts.rd_hold && state_r == S_DRAIN)
    else $error("bad read-out load");

endmodule

// ----- rtl/ebid_dp.sv -----
// Datapath: note header parsing, build-id store and output register.
module ebid_dp #(
  parameter int unsigned MAX_ID_BYTES = ebid_pkg::MAX_ID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_note_byte,
  input  logic                in_last_byte,
  input  ebid_pkg::ebid_cmd_t cmd,
  output ebid_pkg::ebid_sts_t sts,
  ebid_out_if.source          out_if
);
  import ebid_pkg::*;

  localparam int unsigned AW = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_ID_BYTES + 1);
  localparam logic [31:0] MAX_LEN  = 32'(MAX_ID_BYTES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ID_BYTES);

  typedef enum logic [5:0] {
    PH_HEADER     = 6'b000001,
    PH_NAME_SKIP  = 6'b000010,
    PH_DESC_SKIP  = 6'b000100,
    PH_NAME_CHECK = 6'b001000,
    PH_COLLECT    = 6'b010000,
    PH_DONE       = 6'b100000
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [3:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]    name_len_r, name_len_nxt;
  logic [31:0]    desc_len_r, desc_len_nxt;
  logic [31:0]    kind_r, kind_nxt;
  logic [32:0]    skip_r, skip_nxt;
  logic           match_r, match_nxt;
  logic [CW-1:0]  stored_r, stored_nxt;
  logic           found_r, found_nxt;
  logic [CW-1:0]  rd_idx_r;
  logic [CW-1:0]  drain_len_r;
  logic           rd_hold_r;
  logic [7:0]     mem_q_r;
  logic [7:0]     id_mem [MAX_ID_BYTES];

  logic           out_valid_r;
  status_t        out_status_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;

  logic [32:0]    name_pad, desc_pad, skip_dec;
  logic [31:0]    kind_full;
  logic           desc_short, match_now;
  logic           wr_en, single_v, start_run;
  status_t        single_st;
  logic [CW-1:0]  run_len;

  // Padded lengths and header assembly helpers
  assign name_pad   = ({1'b0, name_len_r} + 33'd3) & ~33'd3;
  assign desc_pad   = ({1'b0, desc_len_r} + 33'd3) & ~33'd3;
  assign skip_dec   = skip_r - 33'd1;
  assign kind_full  = {in_note_byte, kind_r[23:0]};
  assign desc_short = desc_len_r <= MAX_LEN;
  assign match_now  = match_r & (in_note_byte == gnu_byte(2'd0 - skip_r[1:0]));

  // Parser next state for the beat on the input
  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    name_len_nxt = name_len_r;
    desc_len_nxt = desc_len_r;
    kind_nxt     = kind_r;
    skip_nxt     = skip_r;
    match_nxt    = match_r;
    stored_nxt   = stored_r;
    found_nxt    = found_r;
    wr_en        = 1'b0;
    single_v     = 1'b0;
    single_st    = ST_NONE;
    start_run    = 1'b0;
    run_len      = stored_r + CW'(1);

    unique case (phase_r)
      PH_HEADER: begin
        hdr_cnt_nxt = hdr_cnt_r + 4'd1;
        // little-endian byte lanes of the three header words
        unique case (hdr_cnt_r[3:2])
          2'd0: begin
            unique case (hdr_cnt_r[1:0])
              2'd0:    name_len_nxt[7:0]   = in_note_byte;
              2'd1:    name_len_nxt[15:8]  = in_note_byte;
              2'd2:    name_len_nxt[23:16] = in_note_byte;
              default: name_len_nxt[31:24] = in_note_byte;
            endcase
          end
          2'd1: begin
            unique case (hdr_cnt_r[1:0])
              2'd0:    desc_len_nxt[7:0]   = in_note_byte;
              2'd1:    desc_len_nxt[15:8]  = in_note_byte;
              2'd2:    desc_len_nxt[23:16] = in_note_byte;
              default: desc_len_nxt[31:24] = in_note_byte;
            endcase
          end
          default: begin
            unique case (hdr_cnt_r[1:0])
              2'd0:    kind_nxt[7:0]   = in_note_byte;
              2'd1:    kind_nxt[15:8]  = in_note_byte;
              2'd2:    kind_nxt[23:16] = in_note_byte;
              default: kind_nxt[31:24] = in_note_byte;
            endcase
          end
        endcase
        if (hdr_cnt_r == HDR_LAST_IDX) begin
          hdr_cnt_nxt = 4'd0;
          if (kind_full == NOTE_TYPE_BUILD_ID && name_len_r == NOTE_NAME_SIZE) begin
            phase_nxt = PH_NAME_CHECK;
            skip_nxt  = 33'd4;
            match_nxt = 1'b1;
          end else if (name_len_r != 32'd0) begin
            phase_nxt = PH_NAME_SKIP;
            skip_nxt  = name_pad;
          end else if (desc_len_r != 32'd0) begin
            phase_nxt = PH_DESC_SKIP;
            skip_nxt  = desc_pad;
          end else begin
            skip_nxt  = 33'd0;
          end
        end
      end
      PH_NAME_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_r == 33'd1) begin
          if (desc_len_r != 32'd0) begin
            phase_nxt = PH_DESC_SKIP;
            skip_nxt  = desc_pad;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_DESC_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_r == 33'd1) phase_nxt = PH_HEADER;
      end
      PH_NAME_CHECK: begin
        skip_nxt  = skip_dec;
        match_nxt = match_now;
        if (skip_r == 33'd1) begin
          if (!match_now) begin
            if (desc_len_r != 32'd0) begin
              phase_nxt = PH_DESC_SKIP;
              skip_nxt  = desc_pad;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end else if (desc_len_r == 32'd0) begin
            // matching note with an empty descriptor
            single_v  = 1'b1;
            single_st = ST_EMPTY;
            found_nxt = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt  = PH_COLLECT;
            skip_nxt   = {1'b0, desc_len_r};
            stored_nxt = '0;
          end
        end
      end
      PH_COLLECT: begin
        skip_nxt = skip_dec;
        if (desc_short && stored_r < MAX_CNT) begin
          wr_en      = 1'b1;
          stored_nxt = stored_r + CW'(1);
        end
        if (skip_r == 33'd1) begin
          found_nxt = 1'b1;
          phase_nxt = PH_DONE;
          if (!desc_short) begin
            single_v  = 1'b1;
            single_st = ST_LONG;
          end else begin
            start_run = 1'b1;
          end
        end
      end
      PH_DONE: ;
      default: phase_nxt = PH_HEADER;
    endcase

    // End of region: report a miss, then clear parse state
    if (in_last_byte) begin
      if (!found_nxt) begin
        single_v  = 1'b1;
        single_st = ST_NONE;
      end
      phase_nxt    = PH_HEADER;
      hdr_cnt_nxt  = 4'd0;
      name_len_nxt = 32'd0;
      desc_len_nxt = 32'd0;
      kind_nxt     = 32'd0;
      skip_nxt     = 33'd0;
      match_nxt    = 1'b1;
      stored_nxt   = '0;
      found_nxt    = 1'b0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= 4'd0;
      name_len_r <= 32'd0;
      desc_len_r <= 32'd0;
      kind_r     <= 32'd0;
      skip_r     <= 33'd0;
      match_r    <= 1'b1;
      stored_r   <= '0;
      found_r    <= 1'b0;
    end else if (cmd.take) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      name_len_r <= name_len_nxt;
      desc_len_r <= desc_len_nxt;
      kind_r     <= kind_nxt;
      skip_r     <= skip_nxt;
      match_r    <= match_nxt;
      stored_r   <= stored_nxt;
      found_r    <= found_nxt;
    end
  end

  // Build-id store: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) id_mem[stored_r[AW-1:0]] <= in_note_byte;
    if (cmd.issue) mem_q_r <= id_mem[rd_idx_r[AW-1:0]];
  end

  // Read-out pointer and run length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      drain_len_r <= '0;
      rd_hold_r   <= 1'b0;
    end else begin
      if (cmd.take && start_run) begin
        rd_idx_r    <= '0;
        drain_len_r <= run_len;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (cmd.issue) rd_hold_r <= 1'b1;
      else if (cmd.load_run) rd_hold_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.take && single_v) || cmd.load_run) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      out_status_r <= ST_BYTE;
      out_byte_r   <= mem_q_r;
      out_last_r   <= (rd_idx_r == drain_len_r);
    end else if (cmd.take && single_v) begin
      out_status_r <= single_st;
      out_byte_r   <= 8'h00;
      out_last_r   <= 1'b1;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.id_byte     = out_byte_r;
  assign out_if.last_of_run = out_last_r;

  assign sts.start_run = start_run;
  assign sts.out_free  = ~out_valid_r | out_if.ready;
  assign sts.rd_left   = (rd_idx_r != drain_len_r);
  assign sts.rd_hold   = rd_hold_r;

  // Read pointer never passes the run length
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= drain_len_r)
    else $error("read pointer past run length");

  // Status-only results are always single-beat runs
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_BYTE |-> out_last_r && out_byte_r == 8'h00)
    else $error("status result not a closed run");

  // A stored descriptor never exceeds the store
  a_store_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= MAX_CNT)
    else $error("store count overflow");

endmodule

// ----- rtl/elf_build_id_note_scanner.sv -----
// Top level: GNU build-id note scanner over a byte stream of ELF notes.
//
//   channel | dir | payload                          | beat
//   in_if   | in  | note_byte[7:0], last_byte        | one region byte
//   out_if  | out | status[1:0], id_byte[7:0],       | one result
//           |     | last_of_run                      |
//
// One input byte per cycle while parsing; results for a byte are registered
// and the next byte is taken while a single result waits if the sink takes it.
// A found build id of N bytes is read from the id store one byte per cycle
// while the sink keeps up; intake pauses for the read-out (a registered store
// read, then N beats), longer if the result sink stalls.
// Reset (rst_n low, synchronous) returns the parser to the header phase.
module elf_build_id_note_scanner #(
  parameter int unsigned MAX_ID_BYTES = ebid_pkg::MAX_ID_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ebid_in_if.sink   in_if,
  ebid_out_if.source out_if
);
  import ebid_pkg::*;

  ebid_sts_t sts;
  ebid_cmd_t cmd;

  ebid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ebid_dp #(
    .MAX_ID_BYTES (MAX_ID_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_note_byte (in_if.note_byte),
    .in_last_byte (in_if.last_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_if       (out_if)
  );

endmodule
